@@ rtl/ets_pkg.sv @@
// Shared types, codes and constant tables of the task table scheduler.
package ets_pkg;

   // Request codes
   localparam logic [2:0] REQ_CREATE   = 3'd0;
   localparam logic [2:0] REQ_SET_EXEC = 3'd1;
   localparam logic [2:0] REQ_SET_DL   = 3'd2;
   localparam logic [2:0] REQ_SET_RATE = 3'd3;
   localparam logic [2:0] REQ_SET_POL  = 3'd4;
   localparam logic [2:0] REQ_SET_ST   = 3'd5;
   localparam logic [2:0] REQ_PICK     = 3'd6;
   localparam logic [2:0] REQ_NOP      = 3'd7;

   // Status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NO_PID   = 2'd1;
   localparam logic [1:0] STS_REJECT   = 2'd2;
   localparam logic [1:0] STS_NO_SLOT  = 2'd3;

   // Task states
   localparam logic [2:0] TS_UNUSED    = 3'd0;
   localparam logic [2:0] TS_EMBRYO    = 3'd1;
   localparam logic [2:0] TS_RUNNABLE  = 3'd3;
   localparam logic [2:0] TS_RUNNING   = 3'd4;
   localparam logic [2:0] TS_ZOMBIE    = 3'd5;

   // Policies
   localparam logic [1:0] POL_EDF      = 2'd0;
   localparam logic [1:0] POL_RM       = 2'd1;
   localparam logic [1:0] POL_NONE     = 2'd3;

   localparam int DIV_W    = 23;
   localparam int DIVS_W   = 16;
   localparam int LIMIT_W  = 10;
   localparam int RESET_LIMIT = 100;

   typedef struct packed {
      logic [15:0] pid;
      logic [15:0] deadline;
      logic [15:0] wcet;
      logic [15:0] rate;
      logic [7:0]  prio;
      logic [1:0]  policy;
      logic [31:0] elapsed;
      logic        killed;
      logic [31:0] arrival;
   } ets_rec_type;

   // Priority from rate: (118 - 3*rate)/29, at least 1.
   function automatic logic [7:0] rate_priority(input logic [15:0] rate);
      logic [7:0] t;
      logic [7:0] p;
      t = 8'd118 - (8'({2'b00, rate[5:0]}) * 8'd3);
      if (rate > 16'd39) begin
         p = 8'd1;
      end else if (t >= 8'd116) begin
         p = 8'd4;
      end else if (t >= 8'd87) begin
         p = 8'd3;
      end else if (t >= 8'd58) begin
         p = 8'd2;
      end else begin
         p = 8'd1;
      end
      return p;
   endfunction

   // Rate-monotonic utilisation bound, in tenths of a percent.
   function automatic logic [9:0] rm_bound(input logic [15:0] pid);
      logic [5:0] i;
      logic [9:0] b;
      i = 6'(pid - 16'd2);
      case (i)
         6'd1: b = 10'd1000; 6'd2: b = 10'd828; 6'd3: b = 10'd779; 6'd4: b = 10'd756;
         6'd5: b = 10'd743;  6'd6: b = 10'd734; 6'd7: b = 10'd728; 6'd8: b = 10'd724;
         6'd9: b = 10'd720;  6'd10: b = 10'd717; 6'd11: b = 10'd715; 6'd12: b = 10'd713;
         6'd13: b = 10'd711; 6'd14: b = 10'd710; 6'd15: b = 10'd709; 6'd16: b = 10'd708;
         6'd17: b = 10'd707; 6'd18: b = 10'd706; 6'd19: b = 10'd705; 6'd20: b = 10'd705;
         6'd21: b = 10'd704; 6'd22: b = 10'd704; 6'd23: b = 10'd703; 6'd24: b = 10'd703;
         6'd25: b = 10'd702; 6'd26: b = 10'd702; 6'd27: b = 10'd702; 6'd28: b = 10'd701;
         6'd29: b = 10'd701; 6'd30: b = 10'd701; 6'd31: b = 10'd700; 6'd32: b = 10'd700;
         6'd33: b = 10'd700; 6'd34: b = 10'd700; 6'd35: b = 10'd700; 6'd36: b = 10'd699;
         6'd37: b = 10'd699; 6'd38: b = 10'd699; 6'd39: b = 10'd699; 6'd40: b = 10'd699;
         6'd41: b = 10'd699; 6'd42: b = 10'd698; 6'd43: b = 10'd698; 6'd44: b = 10'd698;
         6'd45: b = 10'd698; 6'd46: b = 10'd698; 6'd47: b = 10'd698; 6'd48: b = 10'd698;
         6'd49: b = 10'd698; 6'd50: b = 10'd697; 6'd51: b = 10'd697; 6'd52: b = 10'd697;
         6'd53: b = 10'd697; 6'd54: b = 10'd697; 6'd55: b = 10'd697; 6'd56: b = 10'd697;
         6'd57: b = 10'd697; 6'd58: b = 10'd697; 6'd59: b = 10'd697; 6'd60: b = 10'd697;
         6'd61: b = 10'd697; 6'd62: b = 10'd697; 6'd63: b = 10'd696;
         default: b = 10'd696;
      endcase
      if (pid < 16'd3 || pid > 16'd65) begin
         b = 10'd696;
      end
      return b;
   endfunction

endpackage

@@ rtl/ets_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ets_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/ets_div.sv @@
// Restoring divider for the EDF utilisation, one quotient bit per cycle.
module ets_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ets_pkg::DIV_W-1:0]   dividend,
   input  logic [ets_pkg::DIVS_W-1:0]  divisor,
   output logic                        done,
   output logic [ets_pkg::DIV_W-1:0]   quotient
);
   import ets_pkg::*;

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  q_ff, q_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] d_ff, d_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[DIV_W-1]};
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         d_in   = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = DIVS_W'(trial - {1'b0, d_ff});
            q_in   = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_W-1:0];
            q_in   = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

@@ rtl/edf_rm_task_table_scheduler_unit.sv @@
// Top level of the task table scheduler: request sequencer over the slot memories.
//
//   channel   ports                               handshake
//   request   req_type, req_task_pid, ...         start, accepted when busy is low
//   result    rsp_status, rsp_result_pid/slot     rsp_strobe, one cycle
//   config    csr_wr_data                         csr_wr_en
//
// Create and pid requests scan the slot memories one entry a cycle.
// An EDF policy request with a deadline also runs the serial divider; an RM one the multiply and check states.
// Pick scans up to twice. The scans and the divider or multiply states set the rate.
// Reset is synchronous; slot state reads as unused until a slot is first written.
// The receiver cannot stall; busy stays high until the result strobe.
module edf_rm_task_table_scheduler_unit #(
   parameter int TASK_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_task_pid,
   input  logic [15:0] req_arg_value,
   input  logic [31:0] req_current_tick,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_result_pid,
   output logic [5:0]  rsp_result_slot,
   input  logic        csr_wr_en,
   input  logic [ets_pkg::LIMIT_W-1:0] csr_wr_data
);
   import ets_pkg::*;

   localparam int SW = $clog2(TASK_SLOTS);
   localparam int RW = $bits(ets_rec_type);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SCAN1 = 8'b0000_0010,
      S_SCAN2 = 8'b0000_0100,
      S_DIV   = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_MUL10 = 8'b0010_0000,
      S_RMCHK = 8'b0100_0000,
      S_WB    = 8'b1000_0000
   } ets_fsm_type;

   ets_fsm_type fsm_ff, fsm_in;

   logic [2:0]  op_ff, op_in;
   logic [15:0] pid_ff, pid_in;
   logic [15:0] arg_ff, arg_in;
   logic [31:0] tick_ff, tick_in;

   logic [SW:0]   k_ff, k_in;
   logic [SW-1:0] addr_ff, addr_in;
   logic          rd_live_ff, rd_live_in;
   logic [SW-1:0] rd_idx_ff, rd_idx_in;

   logic [SW-1:0] slot_ff, slot_in;
   ets_rec_type   rec_ff, rec_in;
   logic          rec_en_ff, rec_en_in;
   logic          st_en_ff, st_en_in;
   logic [2:0]    st_wr_ff, st_wr_in;
   logic [1:0]    status_ff, status_in;
   logic [1:0]    kpol_ff, kpol_in;

   logic [31:0] prod_ff, prod_in;
   logic [35:0] util_ff, util_in;

   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [15:0]   next_pid_ff, next_pid_in;
   logic [31:0]   edf_total_ff, edf_total_in;
   logic [31:0]   rm_total_ff, rm_total_in;
   logic [SW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic        strobe_ff, strobe_in;
   logic [1:0]  o_status_ff, o_status_in;
   logic [15:0] o_pid_ff, o_pid_in;
   logic [SW-1:0] o_slot_ff, o_slot_in;

   logic [2:0]  st_rd;
   logic [RW-1:0] rec_rd_bits;
   ets_rec_type rec_rd;
   logic [2:0]  eff_st;
   logic        issue;
   logic        scan_end;
   logic        div_start;
   logic [DIV_W-1:0] div_num;
   logic        div_done;
   logic [DIV_W-1:0] div_q;
   logic [32:0] edf_sum;
   logic [36:0] rm_sum;
   logic [SW+5:0] slot_ext;

   function automatic logic better(input ets_rec_type a, input ets_rec_type b,
                                   input logic [1:0] pol);
      logic [15:0] ka;
      logic [15:0] kb;
      ka = (pol == POL_EDF) ? a.deadline : {8'd0, a.prio};
      kb = (pol == POL_EDF) ? b.deadline : {8'd0, b.prio};
      return (ka < kb) || ((ka == kb) && (a.pid < b.pid));
   endfunction

   ets_ram #(.WIDTH(3), .DEPTH(TASK_SLOTS)) u_state_ram (
      .clock   (clock),
      .wr_en   ((fsm_ff == S_WB) && st_en_ff),
      .wr_addr (slot_ff),
      .wr_data (st_wr_ff),
      .rd_addr (addr_ff),
      .rd_data (st_rd)
   );

   ets_ram #(.WIDTH(RW), .DEPTH(TASK_SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   ((fsm_ff == S_WB) && rec_en_ff),
      .wr_addr (slot_ff),
      .wr_data (rec_ff),
      .rd_addr (addr_ff),
      .rd_data (rec_rd_bits)
   );

   ets_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (rec_rd.deadline),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rec_rd   = ets_rec_type'(rec_rd_bits);
   assign eff_st   = valid_ff[rd_idx_ff] ? st_rd : TS_UNUSED;
   assign issue    = (k_ff < (SW+1)'(TASK_SLOTS));
   assign scan_end = !issue && !rd_live_ff;
   assign div_num  = DIV_W'({7'd0, rec_rd.wcet} * 23'd100);
   assign edf_sum  = {1'b0, edf_total_ff} + 33'(div_q);
   assign rm_sum   = {5'd0, rm_total_ff} + {1'b0, util_ff};

   always_comb begin
      fsm_in       = fsm_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      arg_in       = arg_ff;
      tick_in      = tick_ff;
      k_in         = k_ff;
      addr_in      = addr_ff;
      rd_live_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      slot_in      = slot_ff;
      rec_in       = rec_ff;
      rec_en_in    = rec_en_ff;
      st_en_in     = st_en_ff;
      st_wr_in     = st_wr_ff;
      status_in    = status_ff;
      kpol_in      = kpol_ff;
      prod_in      = prod_ff;
      util_in      = util_ff;
      valid_in     = valid_ff;
      next_pid_in  = next_pid_ff;
      edf_total_in = edf_total_ff;
      rm_total_in  = rm_total_ff;
      scan_ptr_in  = scan_ptr_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      strobe_in    = 1'b0;
      o_status_in  = o_status_ff;
      o_pid_in     = o_pid_ff;
      o_slot_in    = o_slot_ff;
      div_start    = 1'b0;

      case (fsm_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_type;
               pid_in    = req_task_pid;
               arg_in    = req_arg_value;
               tick_in   = req_current_tick;
               k_in      = '0;
               addr_in   = (req_type == REQ_PICK) ? scan_ptr_ff : '0;
               rec_en_in = 1'b0;
               st_en_in  = 1'b0;
               status_in = STS_OK;
               if (req_type == REQ_NOP) begin
                  fsm_in = S_WB;
               end else begin
                  fsm_in = S_SCAN1;
               end
            end
         end

         S_SCAN1: begin
            if (issue) begin
               rd_live_in = 1'b1;
               rd_idx_in  = addr_ff;
               k_in       = k_ff + 1'b1;
               addr_in    = (addr_ff == SW'(TASK_SLOTS - 1)) ? '0 : addr_ff + 1'b1;
            end
            if (rd_live_ff && (
                  ((op_ff == REQ_CREATE) && (eff_st == TS_UNUSED)) ||
                  ((op_ff == REQ_PICK) && (eff_st == TS_RUNNABLE)) ||
                  ((op_ff != REQ_CREATE) && (op_ff != REQ_PICK) &&
                   (eff_st != TS_UNUSED) && (rec_rd.pid == pid_ff)))) begin
               rd_live_in = 1'b0;
               slot_in    = rd_idx_ff;
               rec_in     = rec_rd;
               fsm_in     = S_WB;
               case (op_ff)
                  REQ_CREATE: begin
                     rec_in.pid       = next_pid_ff;
                     rec_in.deadline  = '0;
                     rec_in.wcet      = 16'd1;
                     rec_in.rate      = '0;
                     rec_in.prio      = 8'd1;
                     rec_in.policy    = POL_NONE;
                     rec_in.elapsed   = '0;
                     rec_in.killed    = 1'b0;
                     rec_in.arrival   = '0;
                     rec_en_in        = 1'b1;
                     st_en_in         = 1'b1;
                     st_wr_in         = TS_EMBRYO;
                  end
                  REQ_SET_EXEC: begin
                     rec_in.wcet = arg_ff;
                     rec_en_in   = 1'b1;
                  end
                  REQ_SET_DL: begin
                     rec_in.deadline = arg_ff;
                     rec_en_in       = 1'b1;
                  end
                  REQ_SET_RATE: begin
                     rec_in.rate = arg_ff;
                     rec_in.prio = rate_priority(arg_ff);
                     rec_en_in   = 1'b1;
                  end
                  REQ_SET_POL: begin
                     if (arg_ff == 16'd0) begin
                        if (rec_rd.deadline == 16'd0) begin
                           rec_in.killed = 1'b1;
                           rec_en_in     = 1'b1;
                           st_en_in      = 1'b1;
                           st_wr_in      = TS_ZOMBIE;
                           status_in     = STS_REJECT;
                        end else begin
                           div_start = 1'b1;
                           fsm_in    = S_DIV;
                        end
                     end else if (arg_ff == 16'd1) begin
                        fsm_in = S_MUL;
                     end
                  end
                  REQ_SET_ST: begin
                     if (arg_ff <= 16'(TS_ZOMBIE)) begin
                        st_en_in = 1'b1;
                        st_wr_in = arg_ff[2:0];
                     end
                  end
                  REQ_PICK: begin
                     st_en_in = 1'b1;
                     st_wr_in = TS_RUNNING;
                     kpol_in  = rec_rd.policy;
                     if (rec_rd.policy == POL_EDF || rec_rd.policy == POL_RM) begin
                        k_in    = '0;
                        addr_in = '0;
                        fsm_in  = S_SCAN2;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (scan_end) begin
               status_in = (op_ff == REQ_CREATE || op_ff == REQ_PICK) ? STS_NO_SLOT
                                                                       : STS_NO_PID;
               fsm_in    = S_WB;
            end
         end

         S_SCAN2: begin
            // The key policy is that of the task found first; rec_ff holds the best so far.
            if (issue) begin
               rd_live_in = 1'b1;
               rd_idx_in  = addr_ff;
               k_in       = k_ff + 1'b1;
               addr_in    = (addr_ff == SW'(TASK_SLOTS - 1)) ? '0 : addr_ff + 1'b1;
            end
            if (rd_live_ff && (eff_st == TS_RUNNABLE) &&
                better(rec_rd, rec_ff, kpol_ff)) begin
               rec_in         = rec_rd;
               rec_in.elapsed = rec_rd.elapsed;
               slot_in        = rd_idx_ff;
            end
            if (scan_end) begin
               fsm_in = S_WB;
            end
         end

         S_DIV: begin
            if (div_done) begin
               rec_en_in = 1'b1;
               fsm_in    = S_WB;
               if (edf_sum >= 33'(limit_ff)) begin
                  rec_in.killed = 1'b1;
                  st_en_in      = 1'b1;
                  st_wr_in      = TS_ZOMBIE;
                  status_in     = STS_REJECT;
               end else begin
                  edf_total_in  = edf_sum[31:0];
                  rec_in.policy = POL_EDF;
               end
            end
         end

         S_MUL: begin
            prod_in = {16'd0, rec_ff.wcet} * {16'd0, rec_ff.rate};
            fsm_in  = S_MUL10;
         end

         S_MUL10: begin
            util_in = {1'b0, prod_ff, 3'd0} + {3'd0, prod_ff, 1'b0};
            fsm_in  = S_RMCHK;
         end

         S_RMCHK: begin
            rec_en_in = 1'b1;
            fsm_in    = S_WB;
            if (rm_sum > 37'(rm_bound(pid_ff))) begin
               rec_in.killed = 1'b1;
               st_en_in      = 1'b1;
               st_wr_in      = TS_ZOMBIE;
               status_in     = STS_REJECT;
            end else begin
               rm_total_in    = rm_sum[31:0];
               rec_in.arrival = tick_ff;
               rec_in.policy  = POL_RM;
            end
         end

         S_WB: begin
            strobe_in   = 1'b1;
            o_status_in = status_ff;
            o_pid_in    = '0;
            o_slot_in   = '0;
            fsm_in      = S_IDLE;
            if (st_en_ff) begin
               valid_in[slot_ff] = 1'b1;
            end
            if (status_ff == STS_OK) begin
               if (op_ff == REQ_CREATE) begin
                  next_pid_in = next_pid_ff + 16'd1;
                  o_pid_in    = rec_ff.pid;
                  o_slot_in   = slot_ff;
               end else if (op_ff == REQ_PICK) begin
                  o_pid_in    = rec_ff.pid;
                  o_slot_in   = slot_ff;
                  scan_ptr_in = (slot_ff == SW'(TASK_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
               end
            end
         end

         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   // The elapsed count of a picked task under a policy is bumped on the way out.
   ets_rec_type rec_wb;
   always_comb begin
      rec_wb = rec_in;
      if ((fsm_ff == S_SCAN2) && (fsm_in == S_WB)) begin
         rec_wb.elapsed = rec_in.elapsed + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= S_IDLE;
         rd_live_ff   <= 1'b0;
         valid_ff     <= '0;
         next_pid_ff  <= 16'd1;
         edf_total_ff <= '0;
         rm_total_ff  <= '0;
         scan_ptr_ff  <= '0;
         limit_ff     <= LIMIT_W'(RESET_LIMIT);
         strobe_ff    <= 1'b0;
         rec_en_ff    <= 1'b0;
         st_en_ff     <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rd_live_ff   <= rd_live_in;
         valid_ff     <= valid_in;
         next_pid_ff  <= next_pid_in;
         edf_total_ff <= edf_total_in;
         rm_total_ff  <= rm_total_in;
         scan_ptr_ff  <= scan_ptr_in;
         limit_ff     <= limit_in;
         strobe_ff    <= strobe_in;
         rec_en_ff    <= ((fsm_ff == S_SCAN2) && (fsm_in == S_WB)) ? 1'b1 : rec_en_in;
         st_en_ff     <= st_en_in;
      end
      op_ff       <= op_in;
      pid_ff      <= pid_in;
      arg_ff      <= arg_in;
      tick_ff     <= tick_in;
      k_ff        <= k_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      slot_ff     <= slot_in;
      rec_ff      <= rec_wb;
      st_wr_ff    <= st_wr_in;
      status_ff   <= status_in;
      kpol_ff     <= kpol_in;
      prod_ff     <= prod_in;
      util_ff     <= util_in;
      o_status_ff <= o_status_in;
      o_pid_ff    <= o_pid_in;
      o_slot_ff   <= o_slot_in;
   end

   assign slot_ext        = (SW+6)'(o_slot_ff);
   assign busy            = (fsm_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_result_pid  = o_pid_ff;
   assign rsp_result_slot = slot_ext[5:0];
endmodule
